FILE: hdl/fssad_pkg.sv
package fssad_pkg;

    // datapath geometry
    localparam int LANES          = 16;
    localparam int PIX_W          = 8;
    localparam int ROW_SUM_W      = 12;
    localparam int SAD_W          = 16;
    localparam int COORD_W        = 12;
    localparam int OFF_W          = 5;
    localparam int FRAME_W        = 13;
    localparam int DEF_BLK_ROWS   = 16;

    // largest offset magnitude that still counts as a valid candidate
    localparam int SEARCH_RANGE   = 8;

    // reset values
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [SAD_W-1:0]   SAD_NONE         = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // per-candidate information carried along the row pipeline
    typedef struct packed {
        logic                    in_frame;
        logic                    last;
        logic signed [OFF_W-1:0] dx;
        logic signed [OFF_W-1:0] dy;
    } t_cand;

endpackage

FILE: hdl/fssad_lane.sv
module fssad_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [fssad_pkg::PIX_W-1:0] i_cur,
    input  logic [fssad_pkg::PIX_W-1:0] i_ref,
    output logic [fssad_pkg::PIX_W-1:0] o_diff
);
    import fssad_pkg::*;

    logic [PIX_W-1:0] r_diff;

    // absolute difference of one pixel pair
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= (i_cur > i_ref) ? (i_cur - i_ref) : (i_ref - i_cur);
        end
    end

    assign o_diff = r_diff;

endmodule

FILE: hdl/fssad_row_merge.sv
module fssad_row_merge (
    input  logic                                              i_clk,
    input  logic                                              i_en,
    input  logic [fssad_pkg::LANES-1:0][fssad_pkg::PIX_W-1:0] i_diff,
    input  fssad_pkg::t_cand                                  i_cand,
    output logic [fssad_pkg::ROW_SUM_W-1:0]                   o_row_sad,
    output fssad_pkg::t_cand                                  o_cand
);
    import fssad_pkg::*;

    logic [8:0]           lvl1 [8];
    logic [9:0]           lvl2 [4];
    logic [10:0]          lvl3 [2];
    logic [ROW_SUM_W-1:0] row_sum;
    logic [ROW_SUM_W-1:0] r_row_sad;
    t_cand                r_cand;

    // balanced adder tree over the lane results
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            lvl1[i] = {1'b0, i_diff[2*i]} + {1'b0, i_diff[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
        end
        row_sum = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
    end

    // row sum and candidate info move on together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row_sad <= row_sum;
            r_cand    <= i_cand;
        end
    end

    assign o_row_sad = r_row_sad;
    assign o_cand    = r_cand;

endmodule

FILE: hdl/fssad_accum.sv
module fssad_accum #(
    parameter int BLK_ROWS = fssad_pkg::DEF_BLK_ROWS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_row_valid,
    input  logic [fssad_pkg::ROW_SUM_W-1:0]      i_row_sad,
    input  fssad_pkg::t_cand                     i_cand,
    output logic                                 o_stall,
    output logic                                 o_valid,
    input  logic                                 i_out_ready,
    output logic signed [fssad_pkg::OFF_W-1:0]   o_best_offset_x,
    output logic signed [fssad_pkg::OFF_W-1:0]   o_best_offset_y,
    output logic [fssad_pkg::SAD_W-1:0]          o_min_sad,
    output logic                                 o_found
);
    import fssad_pkg::*;

    localparam int              RW       = $clog2(BLK_ROWS);
    localparam logic [RW-1:0]   ROW_LAST = RW'(BLK_ROWS - 1);

    logic [RW-1:0]           r_rows;
    logic [SAD_W-1:0]        r_running;
    logic [SAD_W-1:0]        r_lowest;
    logic signed [OFF_W-1:0] r_low_dx;
    logic signed [OFF_W-1:0] r_low_dy;
    logic                    r_out_valid;
    logic signed [OFF_W-1:0] r_out_dx;
    logic signed [OFF_W-1:0] r_out_dy;
    logic [SAD_W-1:0]        r_out_sad;

    logic                    row_end;
    logic [SAD_W-1:0]        sum_new;
    logic                    take;
    logic                    emit;
    logic                    step;
    logic [SAD_W-1:0]        n_lowest;
    logic signed [OFF_W-1:0] n_low_dx;
    logic signed [OFF_W-1:0] n_low_dy;

    // candidate close, compare against the best so far
    always_comb begin
        row_end  = (r_rows == ROW_LAST);
        sum_new  = r_running + SAD_W'(i_row_sad);
        take     = i_cand.in_frame && (sum_new < r_lowest);
        emit     = i_row_valid && row_end && i_cand.last;
        o_stall  = emit && r_out_valid && !i_out_ready;
        step     = i_row_valid && !o_stall;
        n_lowest = take ? sum_new  : r_lowest;
        n_low_dx = take ? i_cand.dx : r_low_dx;
        n_low_dy = take ? i_cand.dy : r_low_dy;
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= '0;
            r_running <= '0;
            r_lowest  <= SAD_NONE;
            r_low_dx  <= '0;
            r_low_dy  <= '0;
        end else if (step) begin
            if (row_end) begin
                r_rows    <= '0;
                r_running <= '0;
                if (emit) begin
                    r_lowest <= SAD_NONE;
                    r_low_dx <= '0;
                    r_low_dy <= '0;
                end else begin
                    r_lowest <= n_lowest;
                    r_low_dx <= n_low_dx;
                    r_low_dy <= n_low_dy;
                end
            end else begin
                r_rows    <= r_rows + 1'b1;
                r_running <= sum_new;
            end
        end
    end

    // output register, holds a request until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_dx  <= n_low_dx;
            r_out_dy  <= n_low_dy;
            r_out_sad <= n_lowest;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_best_offset_x = r_out_dx;
    assign o_best_offset_y = r_out_dy;
    assign o_min_sad       = r_out_sad;
    assign o_found         = (r_out_sad != SAD_NONE);

    // row counter stays inside the block
    a_rows_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= ROW_LAST)
        else $error("row counter beyond block height");

    // an emitted result clears the search
    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit |=> (r_lowest == SAD_NONE) && (r_running == '0) && (r_rows == '0))
        else $error("search state not cleared after result");

    // a waiting request is never dropped
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("pending result lost");

    // no winner means the offset is still zero
    a_none_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lowest == SAD_NONE |-> (r_low_dx == '0) && (r_low_dy == '0))
        else $error("offset set without a winning candidate");

endmodule

FILE: hdl/full_search_sad_block_matcher_unit.sv
// Full-search SAD block matcher.
// Input channel (i_valid / o_ready): one request per clock, while o_ready is
// high, carries one row of the current block and of a candidate reference
// block, 16 pixels each, with the block position, the candidate offset and
// a last-candidate flag. Each candidate takes BLK_ROWS consecutive requests;
// the position, offset and flag are sampled on its final row.
// Output channel (o_valid / i_ready): after the final row of the last
// candidate one request carries the best offset, its SAD and a found flag.
// After the edge that accepts the last row, the result passes the lane
// difference, adder tree and accumulate/compare registers in turn.
// Throughput: one row per cycle while o_ready is high, set by the 16 absolute
// difference lanes and the single row accumulator, closing one row each cycle.
// Configuration: i_cfg_we writes frame width (index 0) or frame height
// (index 1); write only while idle.
// Reset (synchronous, active low): frame 640 x 480, search state cleared,
// output empty. When the receiver stalls, rows keep flowing; o_ready falls
// only when a second result is ready while the first still waits.
module full_search_sad_block_matcher_unit #(
    parameter int BLK_ROWS = fssad_pkg::DEF_BLK_ROWS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [0:0]                           i_cfg_index,
    input  logic [fssad_pkg::FRAME_W-1:0]        i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [63:0]                          i_current_pixels_low,
    input  logic [63:0]                          i_current_pixels_high,
    input  logic [63:0]                          i_reference_pixels_low,
    input  logic [63:0]                          i_reference_pixels_high,
    input  logic [fssad_pkg::COORD_W-1:0]        i_block_left,
    input  logic [fssad_pkg::COORD_W-1:0]        i_block_top,
    input  logic signed [fssad_pkg::OFF_W-1:0]   i_offset_x,
    input  logic signed [fssad_pkg::OFF_W-1:0]   i_offset_y,
    input  logic                                 i_last_candidate,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [fssad_pkg::OFF_W-1:0]   o_best_offset_x,
    output logic signed [fssad_pkg::OFF_W-1:0]   o_best_offset_y,
    output logic [fssad_pkg::SAD_W-1:0]          o_min_sad,
    output logic                                 o_found
);
    import fssad_pkg::*;

    localparam logic [14:0]        BS_EXT = 15'(BLK_ROWS);
    localparam logic signed [6:0]  SR_HI  = 7'(SEARCH_RANGE);
    localparam logic signed [6:0]  SR_LO  = -SR_HI;

    logic [FRAME_W-1:0]             r_frame_width;
    logic [FRAME_W-1:0]             r_frame_height;
    logic                           r_s1_valid;
    logic                           r_s2_valid;
    t_cand                          r_s1_cand;
    t_cand                          s2_cand;
    t_cand                          in_cand;
    logic [ROW_SUM_W-1:0]           s2_row_sad;
    logic [LANES-1:0][PIX_W-1:0]    lane_diff;
    logic [127:0]                   cur_row;
    logic [127:0]                   ref_row;
    logic [14:0]                    rx;
    logic [14:0]                    ry;
    logic signed [6:0]              dx_ext;
    logic signed [6:0]              dy_ext;
    logic                           stall;
    logic                           en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // bounds and range check of the candidate
    always_comb begin
        rx     = {3'b000, i_block_left} + {{10{i_offset_x[OFF_W-1]}}, i_offset_x};
        ry     = {3'b000, i_block_top}  + {{10{i_offset_y[OFF_W-1]}}, i_offset_y};
        dx_ext = {{2{i_offset_x[OFF_W-1]}}, i_offset_x};
        dy_ext = {{2{i_offset_y[OFF_W-1]}}, i_offset_y};
        in_cand.in_frame = !rx[14] && !ry[14]
                        && ((rx + BS_EXT) <= {2'b00, r_frame_width})
                        && ((ry + BS_EXT) <= {2'b00, r_frame_height})
                        && (dx_ext <= SR_HI) && (dx_ext >= SR_LO)
                        && (dy_ext <= SR_HI) && (dy_ext >= SR_LO);
        in_cand.last = i_last_candidate;
        in_cand.dx   = i_offset_x;
        in_cand.dy   = i_offset_y;
    end

    // pipeline moves unless a finished result cannot be placed
    assign en      = !stall;
    assign o_ready = en;
    assign cur_row = {i_current_pixels_high, i_current_pixels_low};
    assign ref_row = {i_reference_pixels_high, i_reference_pixels_low};

    // one lane per pixel column of the block, unused columns read zero
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        if (g < BLK_ROWS) begin : g_used
            fssad_lane u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_cur  (cur_row[g*PIX_W +: PIX_W]),
                .i_ref  (ref_row[g*PIX_W +: PIX_W]),
                .o_diff (lane_diff[g])
            );
        end else begin : g_unused
            assign lane_diff[g] = '0;
        end
    end

    // stage valids and candidate info beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cand <= in_cand;
        end
    end

    fssad_row_merge u_merge (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_diff    (lane_diff),
        .i_cand    (r_s1_cand),
        .o_row_sad (s2_row_sad),
        .o_cand    (s2_cand)
    );

    fssad_accum #(
        .BLK_ROWS (BLK_ROWS)
    ) u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_row_valid     (r_s2_valid),
        .i_row_sad       (s2_row_sad),
        .i_cand          (s2_cand),
        .o_stall         (stall),
        .o_valid         (o_valid),
        .i_out_ready     (i_ready),
        .o_best_offset_x (o_best_offset_x),
        .o_best_offset_y (o_best_offset_y),
        .o_min_sad       (o_min_sad),
        .o_found         (o_found)
    );

endmodule
